/* hdl/tpf_pkg.sv */
package tpf_pkg;

    // Blend weight scale is 1 << BLEND_SHIFT
    localparam int BLEND_SHIFT = 5;
    // Stored sample width
    localparam int SAMPLE_BITS = 12;

    // Port field widths
    localparam int FIELD_W = 12;
    localparam int NOISE_W = 12;
    localparam int DEB_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Signed width of the blend amount n
    localparam int N_W = NOISE_W + 2;
    // Blend accumulator width
    localparam int MIX_W = SAMPLE_BITS + BLEND_SHIFT + 1;

    localparam logic [BLEND_SHIFT:0] BLEND_ONE = (BLEND_SHIFT + 1)'(1) << BLEND_SHIFT;

    // Reset values of the registers
    localparam logic [NOISE_W-1:0] PRESS_LIMIT_RST = NOISE_W'(38);
    localparam logic [NOISE_W-1:0] HOLD_LIMIT_RST  = NOISE_W'(50);
    localparam logic [DEB_W-1:0]   DEBOUNCE_RST    = DEB_W'(1);

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [BLEND_SHIFT:0]   weight_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_LIMIT = 2'd0,
        CFG_HOLD_LIMIT  = 2'd1,
        CFG_DEBOUNCE    = 2'd2
    } cfg_index_t;

    // (fresh*(R-n) + old*n) >> BLEND_SHIFT, n in 1..R
    function automatic sample_t blend_mix(sample_t fresh, sample_t old, weight_t n);
        logic [MIX_W-1:0] acc;
        weight_t          w;
        w   = BLEND_ONE - n;
        acc = MIX_W'(fresh) * MIX_W'(w) + MIX_W'(old) * MIX_W'(n);
        return acc[SAMPLE_BITS+BLEND_SHIFT-1:BLEND_SHIFT];
    endfunction

endpackage

/* hdl/touch_pen_filter.sv */
// Touch pen filter: one word in per frame, one word out per frame.
// Input channel (s_*): pen-detect bit, X/Y readings with their noisiness,
// Z1/Z2 pressure readings. A zero X or Y means no contact.
// Result channel (m_*): debounced pen_up flag and the held X, Y, Z1, Z2;
// all position and pressure fields read zero while pen_up is 1.
// Config channel (cfg_*): index 0 press noise limit, 1 hold noise limit,
// 2 debounce frames; index 3 is ignored. cfg_ready is always high; write
// only while no word is in flight.
// A result word passes through the input register, then the result register,
// once its input word is accepted. One word per cycle while m_ready is high,
// as the pen state and position registers update on each word that moves
// between the two register stages.
// Stall: when m_ready is low the result register holds, the input register
// holds behind it, and s_ready drops once both are full.
// Reset (aresetn low, synchronous): pen released, debounce count, position
// and pressure cleared, registers back to 38 / 50 / 1, both stages empty.
module touch_pen_filter (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_pen_detect,
    input  logic [tpf_pkg::FIELD_W-1:0]   s_x_value,
    input  logic [tpf_pkg::NOISE_W-1:0]   s_x_noise,
    input  logic [tpf_pkg::FIELD_W-1:0]   s_y_value,
    input  logic [tpf_pkg::NOISE_W-1:0]   s_y_noise,
    input  logic [tpf_pkg::FIELD_W-1:0]   s_z1_value,
    input  logic [tpf_pkg::FIELD_W-1:0]   s_z2_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_pen_up,
    output logic [tpf_pkg::FIELD_W-1:0]   m_touch_x,
    output logic [tpf_pkg::FIELD_W-1:0]   m_touch_y,
    output logic [tpf_pkg::FIELD_W-1:0]   m_touch_z1,
    output logic [tpf_pkg::FIELD_W-1:0]   m_touch_z2,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpf_pkg::FIELD_W-1:0]   cfg_data
);

    // Config registers
    logic [tpf_pkg::NOISE_W-1:0] press_limit_reg;
    logic [tpf_pkg::NOISE_W-1:0] hold_limit_reg;
    logic [tpf_pkg::DEB_W-1:0]   debounce_reg;

    // Input register
    logic                        in_vld_reg;
    logic                        in_detect_reg;
    logic [tpf_pkg::FIELD_W-1:0] in_x_reg;
    logic [tpf_pkg::NOISE_W-1:0] in_xn_reg;
    logic [tpf_pkg::FIELD_W-1:0] in_y_reg;
    logic [tpf_pkg::NOISE_W-1:0] in_yn_reg;
    logic [tpf_pkg::FIELD_W-1:0] in_z1_reg;
    logic [tpf_pkg::FIELD_W-1:0] in_z2_reg;

    // Filter state
    logic                        held_reg,  held_next;
    logic [tpf_pkg::DEB_W-1:0]   deb_reg,   deb_next;
    tpf_pkg::sample_t            pos_x_reg, pos_x_next;
    tpf_pkg::sample_t            pos_y_reg, pos_y_next;
    tpf_pkg::sample_t            z1_reg,    z1_next;
    tpf_pkg::sample_t            z2_reg,    z2_next;

    // Result register
    logic                        out_vld_reg;
    logic                        out_up_reg;
    logic [tpf_pkg::FIELD_W-1:0] out_x_reg;
    logic [tpf_pkg::FIELD_W-1:0] out_y_reg;
    logic [tpf_pkg::FIELD_W-1:0] out_z1_reg;
    logic [tpf_pkg::FIELD_W-1:0] out_z2_reg;

    logic out_free;
    logic advance;
    logic s_take;

    tpf_pkg::sample_t              xv, yv, zv1, zv2;
    logic [tpf_pkg::NOISE_W-1:0]   noise;
    logic [tpf_pkg::NOISE_W-1:0]   limit;
    logic signed [tpf_pkg::N_W-1:0] n_amt;
    logic                          candidate;
    logic                          pressed;
    tpf_pkg::weight_t              n_w;

    // Handshake
    assign out_free  = !out_vld_reg || m_ready;
    assign advance   = in_vld_reg && out_free;
    assign s_ready   = !in_vld_reg || out_free;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_limit_reg <= tpf_pkg::PRESS_LIMIT_RST;
            hold_limit_reg  <= tpf_pkg::HOLD_LIMIT_RST;
            debounce_reg    <= tpf_pkg::DEBOUNCE_RST;
        end else if (cfg_valid) begin
            unique case (tpf_pkg::cfg_index_t'(cfg_index))
                tpf_pkg::CFG_PRESS_LIMIT: press_limit_reg <= cfg_data[tpf_pkg::NOISE_W-1:0];
                tpf_pkg::CFG_HOLD_LIMIT:  hold_limit_reg  <= cfg_data[tpf_pkg::NOISE_W-1:0];
                tpf_pkg::CFG_DEBOUNCE:    debounce_reg    <= cfg_data[tpf_pkg::DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_take) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_detect_reg <= s_pen_detect;
            in_x_reg      <= s_x_value;
            in_xn_reg     <= s_x_noise;
            in_y_reg      <= s_y_value;
            in_yn_reg     <= s_y_noise;
            in_z1_reg     <= s_z1_value;
            in_z2_reg     <= s_z2_value;
        end
    end

    // Noise check, blend and debounce
    always_comb begin
        xv    = tpf_pkg::sample_t'(in_x_reg);
        yv    = tpf_pkg::sample_t'(in_y_reg);
        zv1   = tpf_pkg::sample_t'(in_z1_reg);
        zv2   = tpf_pkg::sample_t'(in_z2_reg);
        noise = (in_xn_reg > in_yn_reg) ? in_xn_reg : in_yn_reg;
        limit = held_reg ? hold_limit_reg : press_limit_reg;
        n_amt = $signed(tpf_pkg::N_W'(noise))
              - ($signed(tpf_pkg::N_W'(hold_limit_reg))
              -  $signed(tpf_pkg::N_W'(tpf_pkg::BLEND_ONE)));
        n_w   = n_amt[tpf_pkg::BLEND_SHIFT:0];

        candidate = in_detect_reg && (xv != '0) && (yv != '0);
        pressed   = candidate && (noise <= limit);

        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        z1_next    = z1_reg;
        z2_next    = z2_reg;
        if (pressed) begin
            z1_next = zv1;
            z2_next = zv2;
            if (!held_reg || n_amt <= 0) begin
                pos_x_next = xv;
                pos_y_next = yv;
            end else if (n_amt <= $signed(tpf_pkg::N_W'(tpf_pkg::BLEND_ONE))) begin
                pos_x_next = tpf_pkg::blend_mix(xv, pos_x_reg, n_w);
                pos_y_next = tpf_pkg::blend_mix(yv, pos_y_reg, n_w);
            end
        end

        held_next = held_reg;
        deb_next  = deb_reg;
        if (deb_reg == '0) begin
            if (held_reg != pressed) begin
                held_next = pressed;
                if (pressed) begin
                    deb_next = debounce_reg;
                end
            end
        end else begin
            deb_next = deb_reg - 1'b1;
        end
    end

    // State update on each processed word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            deb_reg   <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            z1_reg    <= '0;
            z2_reg    <= '0;
        end else if (advance) begin
            held_reg  <= held_next;
            deb_reg   <= deb_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            z1_reg    <= z1_next;
            z2_reg    <= z2_next;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_up_reg <= !held_next;
            out_x_reg  <= held_next ? tpf_pkg::FIELD_W'(pos_x_next) : '0;
            out_y_reg  <= held_next ? tpf_pkg::FIELD_W'(pos_y_next) : '0;
            out_z1_reg <= held_next ? tpf_pkg::FIELD_W'(z1_next) : '0;
            out_z2_reg <= held_next ? tpf_pkg::FIELD_W'(z2_next) : '0;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_pen_up   = out_up_reg;
    assign m_touch_x  = out_x_reg;
    assign m_touch_y  = out_y_reg;
    assign m_touch_z1 = out_z1_reg;
    assign m_touch_z2 = out_z2_reg;

endmodule

/* bench/touch_pen_filter_checker.sv */
`timescale 1ns / 100ps

// Watches the three channels of touch_pen_filter, predicts each result word
// from the accepted input words and register writes, and compares in order.
module touch_pen_filter_checker
    import tpf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_pen_detect,
    input  logic [FIELD_W-1:0]   s_x_value,
    input  logic [NOISE_W-1:0]   s_x_noise,
    input  logic [FIELD_W-1:0]   s_y_value,
    input  logic [NOISE_W-1:0]   s_y_noise,
    input  logic [FIELD_W-1:0]   s_z1_value,
    input  logic [FIELD_W-1:0]   s_z2_value,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_pen_up,
    input  logic [FIELD_W-1:0]   m_touch_x,
    input  logic [FIELD_W-1:0]   m_touch_y,
    input  logic [FIELD_W-1:0]   m_touch_z1,
    input  logic [FIELD_W-1:0]   m_touch_z2,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,

    output int                   errors,
    output int                   outstanding
);

    localparam int BLEND_R    = 1 << BLEND_SHIFT;

    typedef struct packed {
        logic    pen_up;
        sample_t x;
        sample_t y;
        sample_t z1;
        sample_t z2;
    } touch_word_t;

    // register copies
    logic [NOISE_W-1:0] press_lim;
    logic [NOISE_W-1:0] hold_lim;
    logic [DEB_W-1:0]   deb_frames;

    // pen state copies
    logic               pen_held;
    logic [DEB_W-1:0]   deb_left;
    sample_t            pos_x;
    sample_t            pos_y;
    sample_t            pres_z1;
    sample_t            pres_z2;

    touch_word_t        words_due[$];
    touch_word_t        want_word;

    // weighted average of fresh and prior sample, weight n on the prior one
    function automatic sample_t blend_axis(sample_t fresh, sample_t prior, int n);
        int unsigned acc;
        acc = int'(fresh) * (BLEND_R - n) + int'(prior) * n;
        return sample_t'(acc >> BLEND_SHIFT);
    endfunction

    // advance the pen state by one frame and return the word it produces
    function automatic touch_word_t next_touch_word(
        input logic               det,
        input sample_t            xv,
        input logic [NOISE_W-1:0] xn,
        input sample_t            yv,
        input logic [NOISE_W-1:0] yn,
        input sample_t            z1,
        input sample_t            z2
    );
        logic               pressed;
        logic [NOISE_W-1:0] noise;
        logic [NOISE_W-1:0] lim;
        int                 n;
        touch_word_t        w;
        pressed = 1'b0;
        if (det && xv != '0 && yv != '0) begin
            noise = (xn > yn) ? xn : yn;
            lim   = pen_held ? hold_lim : press_lim;
            if (noise <= lim) begin
                // n is signed: how far noise sits above (hold limit - R)
                n       = int'(noise) - (int'(hold_lim) - BLEND_R);
                pres_z1 = z1;
                pres_z2 = z2;
                if (!pen_held || n <= 0) begin
                    pos_x = xv;
                    pos_y = yv;
                end else if (n <= BLEND_R) begin
                    pos_x = blend_axis(xv, pos_x, n);
                    pos_y = blend_axis(yv, pos_y, n);
                end
                pressed = 1'b1;
            end
        end

        // debounce: a new press locks the state for deb_frames frames
        if (deb_left == '0) begin
            if (pen_held != pressed) begin
                pen_held = pressed;
                if (pressed)
                    deb_left = deb_frames;
            end
        end else begin
            deb_left = deb_left - 1'b1;
        end

        if (pen_held)
            w = '{pen_up: 1'b0, x: pos_x, y: pos_y, z1: pres_z1, z2: pres_z2};
        else
            w = '{pen_up: 1'b1, x: '0, y: '0, z1: '0, z2: '0};
        return w;
    endfunction

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, label, want, got);
        end
    endtask

    // all three channels are sampled at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            press_lim  = PRESS_LIMIT_RST;
            hold_lim   = HOLD_LIMIT_RST;
            deb_frames = DEBOUNCE_RST;
            pen_held   = 1'b0;
            deb_left   = '0;
            pos_x      = '0;
            pos_y      = '0;
            pres_z1    = '0;
            pres_z2    = '0;
            words_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index_t'(cfg_index))
                    CFG_PRESS_LIMIT: press_lim  = cfg_data;
                    CFG_HOLD_LIMIT:  hold_lim   = cfg_data;
                    CFG_DEBOUNCE:    deb_frames = cfg_data[DEB_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                words_due.push_back(next_touch_word(s_pen_detect, s_x_value, s_x_noise,
                                                    s_y_value, s_y_noise,
                                                    s_z1_value, s_z2_value));

            if (m_valid && m_ready) begin
                if (words_due.size() == 0) begin
                    errors++;
                    $display("%0t: result word with none expected, pen_up %0d x %0d y %0d",
                             $time, m_pen_up, m_touch_x, m_touch_y);
                end else begin
                    want_word = words_due.pop_front();
                    check_field("pen_up",   32'(want_word.pen_up), 32'(m_pen_up));
                    check_field("touch_x",  32'(want_word.x),      32'(m_touch_x));
                    check_field("touch_y",  32'(want_word.y),      32'(m_touch_y));
                    check_field("touch_z1", 32'(want_word.z1),     32'(m_touch_z1));
                    check_field("touch_z2", 32'(want_word.z2),     32'(m_touch_z2));
                end
            end
        end
        outstanding = words_due.size();
    end

endmodule

/* bench/tb_touch_pen_filter.sv */
`timescale 1ns / 100ps

// Drives touch_pen_filter with directed frames and then random pen strokes
// under several register settings; the checker beside the block does the
// prediction, this module only makes traffic and gives the verdict.
module tb_touch_pen_filter;
    import tpf_pkg::*;

    // the fourth register index has no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 230;

    // fixed settings first: all zero, all ones, masked debounce of zero, reset values
    localparam int unsigned PRESS_SET[4] = '{0, 4095, 4095, 38};
    localparam int unsigned HOLD_SET[4]  = '{0, 4095, 0, 50};
    localparam int unsigned DEB_SET[4]   = '{32'h000, 32'hFFF, 32'hF00, 1};

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;

    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic               s_pen_detect = 1'b0;
    logic [FIELD_W-1:0] s_x_value    = '0;
    logic [NOISE_W-1:0] s_x_noise    = '0;
    logic [FIELD_W-1:0] s_y_value    = '0;
    logic [NOISE_W-1:0] s_y_noise    = '0;
    logic [FIELD_W-1:0] s_z1_value   = '0;
    logic [FIELD_W-1:0] s_z2_value   = '0;

    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_pen_up;
    logic [FIELD_W-1:0] m_touch_x;
    logic [FIELD_W-1:0] m_touch_y;
    logic [FIELD_W-1:0] m_touch_z1;
    logic [FIELD_W-1:0] m_touch_z2;

    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [FIELD_W-1:0]   cfg_data   = '0;

    int                 errors;
    int                 outstanding;

    // no idling on either side while set
    logic               calm         = 1'b0;
    int unsigned        stall_left   = 0;
    int unsigned        press_now    = 38;
    int unsigned        hold_now     = 50;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    touch_pen_filter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pen_detect (s_pen_detect),
        .s_x_value    (s_x_value),
        .s_x_noise    (s_x_noise),
        .s_y_value    (s_y_value),
        .s_y_noise    (s_y_noise),
        .s_z1_value   (s_z1_value),
        .s_z2_value   (s_z2_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pen_up     (m_pen_up),
        .m_touch_x    (m_touch_x),
        .m_touch_y    (m_touch_y),
        .m_touch_z1   (m_touch_z1),
        .m_touch_z2   (m_touch_z2),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    touch_pen_filter_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pen_detect (s_pen_detect),
        .s_x_value    (s_x_value),
        .s_x_noise    (s_x_noise),
        .s_y_value    (s_y_value),
        .s_y_noise    (s_y_noise),
        .s_z1_value   (s_z1_value),
        .s_z2_value   (s_z2_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pen_up     (m_pen_up),
        .m_touch_x    (m_touch_x),
        .m_touch_y    (m_touch_y),
        .m_touch_z1   (m_touch_z1),
        .m_touch_z2   (m_touch_z2),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    // gap length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // noisiness clustered around both limits so the hysteresis edges get hit
    function automatic int unsigned pick_noise();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, hold_now);
            5, 6:          v = int'(press_now) + int'($urandom_range(0, 6)) - 3;
            7, 8:          v = int'(hold_now) + int'($urandom_range(0, 6)) - 3;
            default:       v = $urandom_range(0, 4095);
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return unsigned'(v);
    endfunction

    function automatic int unsigned pick_coord();
        if ($urandom_range(0, 19) == 0)
            return 4095;
        return $urandom_range(1, 4095);
    endfunction

    // result side: ready toggles at the falling edge with random stalls
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            stall_left = idle_len();
        end
    end

    // one input word; called and returning at a falling edge
    task automatic send_frame(input logic det, input int unsigned xv, input int unsigned xn,
                              input int unsigned yv, input int unsigned yn,
                              input int unsigned z1, input int unsigned z2);
        int unsigned gap;
        s_valid      = 1'b1;
        s_pen_detect = det;
        s_x_value    = FIELD_W'(xv);
        s_x_noise    = NOISE_W'(xn);
        s_y_value    = FIELD_W'(yv);
        s_y_noise    = NOISE_W'(yn);
        s_z1_value   = FIELD_W'(z1);
        s_z2_value   = FIELD_W'(z2);
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        gap = idle_len();
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_contact();
        send_frame(1'b1, pick_coord(), pick_noise(), pick_coord(), pick_noise(),
                   $urandom_range(0, 4095), $urandom_range(0, 4095));
    endtask

    // lift-off: no detect, or a zero coordinate
    task automatic send_lift();
        case ($urandom_range(0, 2))
            0: send_frame(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
            1: send_frame(1'b1, 0, pick_noise(), pick_coord(), pick_noise(),
                          $urandom_range(0, 4095), $urandom_range(0, 4095));
            default: send_frame(1'b1, pick_coord(), pick_noise(), 0, pick_noise(),
                                $urandom_range(0, 4095), $urandom_range(0, 4095));
        endcase
    endtask

    // anything at all the fields allow
    task automatic send_junk();
        int unsigned xv, yv;
        xv = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095);
        yv = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4095);
        send_frame(1'($urandom_range(0, 1)), xv, $urandom_range(0, 4095), yv,
                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 4095));
    endtask

    // stop sending and wait until every word in flight has come out
    task automatic settle();
        s_valid = 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = FIELD_W'(data);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic set_registers(input int unsigned press, input int unsigned hold,
                                 input int unsigned deb);
        settle();
        write_reg(CFG_SPARE, $urandom_range(0, 4095));
        write_reg(CFG_PRESS_LIMIT, press);
        write_reg(CFG_HOLD_LIMIT, hold);
        write_reg(CFG_DEBOUNCE, deb);
        cfg_valid = 1'b0;
        press_now = press & 32'hFFF;
        hold_now  = hold & 32'hFFF;
    endtask

    // strokes of contact frames separated by lift-offs, some noise mixed in
    task automatic run_strokes(input int quota);
        int sent, stroke, lift, k;
        sent = 0;
        while (sent < quota) begin
            calm   = ($urandom_range(0, 4) == 0);
            stroke = $urandom_range(1, 30);
            for (k = 0; k < stroke; k++) begin
                if ($urandom_range(0, 6) == 0)
                    send_junk();
                else
                    send_contact();
                sent++;
            end
            lift = $urandom_range(1, 6);
            for (k = 0; k < lift; k++) begin
                send_lift();
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin : stimulus
        int p;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // directed frames under reset settings (38 / 50 / 1)
        send_frame(1'b0, 4095, 4095, 4095, 4095, 4095, 4095);  // no detect
        send_frame(1'b1, 0, 0, 2048, 0, 100, 100);             // X zero
        send_frame(1'b1, 2048, 0, 0, 0, 100, 100);             // Y zero
        send_frame(1'b1, 1, 38, 1, 0, 0, 4095);                // noise right at press limit
        send_frame(1'b1, 4095, 4095, 4095, 4095, 7, 7);        // rejected during debounce
        send_frame(1'b1, 4000, 10, 3000, 30, 1, 2);            // held, blended
        send_frame(1'b1, 100, 50, 200, 0, 3, 4);               // full weight on stored position
        send_frame(1'b1, 4095, 0, 4095, 18, 5, 6);             // blend amount zero, taken directly
        send_frame(1'b1, 4095, 0, 4095, 51, 5, 6);             // above hold limit, released
        send_frame(1'b1, 2000, 39, 2000, 0, 9, 9);             // above press limit, not pressed
        send_frame(1'b1, 4095, 0, 4095, 0, 4095, 4095);        // clean press
        send_frame(1'b0, 0, 0, 0, 0, 0, 0);                    // debounce still holds
        send_frame(1'b0, 0, 0, 0, 0, 0, 0);                    // release

        for (p = 0; p < PHASES; p++) begin
            if (p < 4)
                set_registers(PRESS_SET[p], HOLD_SET[p], DEB_SET[p]);
            else
                set_registers($urandom_range(0, 400), $urandom_range(0, 400),
                              $urandom_range(0, 6) | ($urandom_range(0, 15) << 8));
            run_strokes(PHASE_WORDS);
        end

        settle();
        repeat (20) @(negedge aclk);
        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
hdl/tpf_pkg.sv
hdl/touch_pen_filter.sv
bench/touch_pen_filter_checker.sv
bench/tb_touch_pen_filter.sv
